// File: rtl/tfbs_pkg.sv
// ----------------------------------------------------------------------------
// tfbs_pkg: shared types and constants for the typed field byte serializer
// Field type codes, the encoded byte frame, and the coordinate widths of
// the packed position.
// ----------------------------------------------------------------------------
package tfbs_pkg;

  localparam int unsigned MaxBytes   = 10;  // longest run: a 64-bit varint
  localparam int unsigned CntW       = 4;   // holds 0..MaxBytes
  localparam int unsigned PosXzW     = 26;
  localparam int unsigned PosYW      = 12;
  localparam int unsigned LebBits    = 7;   // payload bits per varint byte

  typedef enum logic [2:0] {
    ACT_BOOL     = 3'd0,
    ACT_BYTE     = 3'd1,
    ACT_SHORT    = 3'd2,
    ACT_INT      = 3'd3,
    ACT_LONG     = 3'd4,
    ACT_VARINT   = 3'd5,
    ACT_VARLONG  = 3'd6,
    ACT_POSITION = 3'd7
  } action_t;

  // Encoded run: data[0] goes out first, cnt bytes are meaningful.
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] data;
    logic [CntW-1:0]          cnt;
  } frame_t;

endpackage

// File: rtl/tfbs_if.sv
// ----------------------------------------------------------------------------
// tfbs_if: valid/ready channels of the typed field byte serializer
// tfbs_field_if carries one typed field, tfbs_byte_if one wire byte.
// ----------------------------------------------------------------------------
interface tfbs_field_if;
  logic               valid;
  logic               ready;
  logic [2:0]         action;
  logic [63:0]        value;
  logic signed [25:0] pos_x;
  logic signed [11:0] pos_y;
  logic signed [25:0] pos_z;

  modport source (output valid, action, value, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, action, value, pos_x, pos_y, pos_z, output ready);
endinterface

interface tfbs_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, out_byte, last, input ready);
  modport sink   (input valid, out_byte, last, output ready);
endinterface

// File: rtl/tfbs_encode.sv
// ----------------------------------------------------------------------------
// tfbs_encode: field to byte frame
// Builds the whole wire run of one field (big-endian, LEB128 or packed
// position) in a single pass of combinational logic.
// ----------------------------------------------------------------------------
module tfbs_encode import tfbs_pkg::*; (
  input  logic [2:0]         action,
  input  logic [63:0]        value,
  input  logic signed [25:0] pos_x,
  input  logic signed [11:0] pos_y,
  input  logic signed [25:0] pos_z,
  output frame_t             frame
);

  logic [63:0]                        leb_src;
  logic [MaxBytes-1:0][LebBits-1:0]   grp;
  logic [CntW-1:0]                    top;
  logic [63:0]                        pos_word;

  // Raw coordinate bits, so sign bits never reach a neighbor.
  assign pos_word = {pos_x, pos_y, pos_z};

  // Varint keeps only the low 32 bits, taken as unsigned.
  assign leb_src = (action_t'(action) == ACT_VARINT) ? {32'd0, value[31:0]} : value;

  always_comb begin
    for (int i = 0; i < MaxBytes - 1; i++) begin
      grp[i] = leb_src[LebBits*i +: LebBits];
    end
    grp[MaxBytes-1] = {{(LebBits-1){1'b0}}, leb_src[63]};
  end

  // Highest nonzero 7-bit group; zero gives a single byte.
  always_comb begin
    top = '0;
    for (int i = 1; i < MaxBytes; i++) begin
      if (grp[i] != '0) begin
        top = CntW'(i);
      end
    end
  end

  always_comb begin
    frame = '0;
    case (action_t'(action))
      ACT_BOOL: begin
        frame.data[0] = {7'd0, value[0]};
        frame.cnt     = CntW'(1);
      end
      ACT_BYTE: begin
        frame.data[0] = value[7:0];
        frame.cnt     = CntW'(1);
      end
      ACT_SHORT: begin
        frame.data[0] = value[15:8];
        frame.data[1] = value[7:0];
        frame.cnt     = CntW'(2);
      end
      ACT_INT: begin
        for (int i = 0; i < 4; i++) begin
          frame.data[i] = value[8*(3-i) +: 8];
        end
        frame.cnt = CntW'(4);
      end
      ACT_LONG: begin
        for (int i = 0; i < 8; i++) begin
          frame.data[i] = value[8*(7-i) +: 8];
        end
        frame.cnt = CntW'(8);
      end
      ACT_VARINT, ACT_VARLONG: begin
        for (int i = 0; i < MaxBytes; i++) begin
          frame.data[i] = {(CntW'(i) < top), grp[i]};
        end
        frame.cnt = top + CntW'(1);
      end
      ACT_POSITION: begin
        for (int i = 0; i < 8; i++) begin
          frame.data[i] = pos_word[8*(7-i) +: 8];
        end
        frame.cnt = CntW'(8);
      end
      default: begin
        frame = '0;
      end
    endcase
  end

endmodule

// File: rtl/tfbs_emit.sv
// ----------------------------------------------------------------------------
// tfbs_emit: frame register and byte output register
// Holds one encoded frame and shifts it out a byte per cycle while dst is not
// held; a new frame loads in the cycle its predecessor's last byte moves to the output.
// ----------------------------------------------------------------------------
module tfbs_emit import tfbs_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         take_valid,
  output logic         take_ready,
  input  frame_t       frame_in,
  tfbs_byte_if.source  dst
);

  frame_t     frame_q;
  logic       frame_valid;
  logic [7:0] out_byte;
  logic       out_last;
  logic       out_valid;
  logic       load;
  logic       fin;

  assign load       = frame_valid && (!out_valid || dst.ready);
  assign fin        = load && (frame_q.cnt == CntW'(1));
  assign take_ready = !frame_valid || fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (take_valid && take_ready) begin
        frame_valid <= 1'b1;
      end else if (fin) begin
        frame_valid <= 1'b0;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (dst.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (take_valid && take_ready) begin
      frame_q <= frame_in;
    end else if (load) begin
      frame_q.data <= frame_q.data >> 8;
      frame_q.cnt  <= frame_q.cnt - CntW'(1);
    end
    if (load) begin
      out_byte <= frame_q.data[0];
      out_last <= (frame_q.cnt == CntW'(1));
    end
  end

  assign dst.valid    = out_valid;
  assign dst.out_byte = out_byte;
  assign dst.last     = out_last;

endmodule

// File: rtl/typed_field_byte_serializer.sv
// ----------------------------------------------------------------------------
// typed_field_byte_serializer: typed field to wire byte encoder
// Turns bool, byte, short, int, long, varint, varlong and position fields
// into their wire bytes, one byte per output item, last byte flagged.
// ----------------------------------------------------------------------------
//
//   channel    | dir | payload                         | item
//   -----------+-----+---------------------------------+---------------------
//   field_ch   | in  | action, value, pos_x/y/z        | one typed field
//   byte_ch    | out | out_byte, last                  | one wire byte
//
// Throughput: a field with N wire bytes (1..10) goes out as N byte items;
//   the output register streams one byte every cycle while byte_ch is not
//   held, with no gap between fields, so the rate is set by the single byte
//   output port.
// Path: an accepted field enters the frame register, and its first byte then
//   moves to the output register and onto byte_ch.
// Reset: rst (synchronous) empties the frame and output registers.
// Stalls: a held byte_ch stalls the frame; field_ch is ready whenever the
//   frame register is empty or its final byte moves out this cycle.
//
module typed_field_byte_serializer import tfbs_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  tfbs_field_if.sink   field_ch,
  tfbs_byte_if.source  byte_ch
);

  frame_t frame;

  // Whole run of the incoming field, ready at the accept edge.
  tfbs_encode u_encode (
    .action (field_ch.action),
    .value  (field_ch.value),
    .pos_x  (field_ch.pos_x),
    .pos_y  (field_ch.pos_y),
    .pos_z  (field_ch.pos_z),
    .frame  (frame)
  );

  // Frame register plus byte output register.
  tfbs_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .take_valid (field_ch.valid),
    .take_ready (field_ch.ready),
    .frame_in   (frame),
    .dst        (byte_ch)
  );

endmodule
